// ===== src/trqs_pkg.sv =====
// shared types, constants and the selection compare for the thread ready-queue scheduler
// used by trqs_cell, thread_ready_queue_scheduler, trqs_checker and the testbench; depends on nothing else
package trqs_pkg;

  localparam int MAX_THREADS = 16;
  localparam int CNT_W       = $clog2(MAX_THREADS);

  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_PRIO = 2'd1;
  localparam logic [1:0] MODE_SRTF = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_RETIRE = 2'd3
  } trqs_op_e;

  // command broadcast to every cell
  typedef struct packed {
    trqs_op_e    op;
    logic [1:0]  mode;
    logic [7:0]  tid;
    logic [23:0] arr;
    logic [15:0] left;
    logic [7:0]  prio;
  } trqs_cmd_t;

  // per-cell status back to the control
  typedef struct packed {
    logic valid;
    logic hit;
  } trqs_stat_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic        found;
    logic        is_req;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [23:0] first;
    logic [23:0] last;
    logic [15:0] rem;
    logic [31:0] age;
  } trqs_tok_t;

  // true if candidate a goes ahead of the best so far b
  function automatic logic trqs_prefer(logic [1:0] mode, trqs_tok_t a, trqs_tok_t b);
    logic res;
    if (!b.found) begin
      res = 1'b1;
    end else begin
      case (mode)
        MODE_PRIO: begin
          if (a.prio != b.prio) res = a.prio < b.prio;
          else if (a.first != b.first) res = a.first < b.first;
          else res = a.age < b.age; // newer entry wins an exact tie
        end
        MODE_SRTF: begin
          if (a.rem != b.rem) res = a.rem < b.rem;
          else if (a.last != b.last) res = a.last < b.last;
          else res = a.age > b.age;
        end
        default: res = a.age > b.age; // fcfs, also the unused code
      endcase
    end
    return res;
  endfunction

endpackage

// ===== src/trqs_cell.sv =====
// one table slot of the scheduler: holds a thread entry and compares it against
// the candidate handed in by its left neighbour; depends on trqs_pkg
module trqs_cell import trqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  trqs_cmd_t  cmd_i,
  input  logic       pick_i,
  input  trqs_tok_t  tok_pre_i,
  input  trqs_tok_t  tok_post_i,
  output trqs_tok_t  tok_pre_o,
  output trqs_tok_t  tok_post_o,
  output trqs_stat_t stat_o
);

  logic        valid_q;
  logic        is_req_q;
  logic        doomed_q;
  logic [7:0]  id_q;
  logic [7:0]  prio_q;
  logic [23:0] first_q;
  logic [23:0] last_q;
  logic [15:0] rem_q;
  logic [31:0] age_q;
  trqs_tok_t   mine;
  trqs_tok_t   pre_d, post_d;
  trqs_tok_t   pre_q, post_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      is_req_q <= 1'b0;
      doomed_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_UPDATE: begin
          is_req_q <= pick_i;
          doomed_q <= pick_i && (cmd_i.left == 16'd0);
        end
        OP_INSERT: begin
          is_req_q <= pick_i;
          doomed_q <= 1'b0;
          if (pick_i) valid_q <= 1'b1;
        end
        OP_RETIRE: begin
          if (doomed_q) valid_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // entry payload, meaningful only while valid
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_UPDATE: begin
        if (pick_i) begin
          last_q <= cmd_i.arr;
          rem_q  <= cmd_i.left;
        end
      end
      OP_INSERT: begin
        if (pick_i) begin
          id_q    <= cmd_i.tid;
          prio_q  <= cmd_i.prio;
          first_q <= cmd_i.arr;
          last_q  <= cmd_i.arr;
          rem_q   <= cmd_i.left;
          age_q   <= 32'd1;
        end else begin
          age_q <= age_q + 32'd1; // every insertion ages the rest
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mine.found  = 1'b1;
    mine.is_req = is_req_q;
    mine.id     = id_q;
    mine.prio   = prio_q;
    mine.first  = first_q;
    mine.last   = last_q;
    mine.rem    = rem_q;
    mine.age    = age_q;
    // pre sees the table before removal, post leaves out the finished thread
    pre_d  = (valid_q && trqs_prefer(cmd_i.mode, mine, tok_pre_i)) ? mine : tok_pre_i;
    post_d = (valid_q && !doomed_q && trqs_prefer(cmd_i.mode, mine, tok_post_i)) ?
             mine : tok_post_i;
  end

  always_ff @(posedge clk_i) begin
    pre_q  <= pre_d;
    post_q <= post_d;
  end

  assign tok_pre_o    = pre_q;
  assign tok_post_o   = post_q;
  assign stat_o.valid = valid_q;
  assign stat_o.hit   = valid_q && (id_q == cmd_i.tid);

endmodule

// ===== src/thread_ready_queue_scheduler.sv =====
// thread ready-queue scheduler top level: request control, output register and
// the row of trqs_cell slots; depends on trqs_pkg and trqs_cell
//
// usage
// - request channel: in_valid_i / in_stall_o carry thread_id, arrival_time,
//   time_left and thread_priority; a request is taken when valid is high and
//   stall is low. stall is low only while the block is idle
// - result channel: out_valid_o / out_stall_i carry one result per request
//   (running_id, requester_runs, queue_empty, table_full, tick_count)
// - config channel: cfg_valid_i / cfg_ready_o writes policy_mode; ready is
//   always high, write it only while no request is in flight
// - per request: a lookup step, a scan while the best candidate walks the
//   row of cells one slot per cycle, then a retire step. the result is
//   written to the output register in the retire step, and the next
//   request is taken only once the block is back in idle after it
// - a pending result sits in the output register; a new request is taken
//   meanwhile, but the retire step waits while the receiver stalls
// - reset empties the table, selects fcfs and zeroes the tick counter; no
//   clearing pass is needed
module thread_ready_queue_scheduler import trqs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  thread_id_i,
  input  logic [23:0] arrival_time_i,
  input  logic [15:0] time_left_i,
  input  logic [7:0]  thread_priority_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  policy_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  running_id_o,
  output logic        requester_runs_o,
  output logic        queue_empty_o,
  output logic        table_full_o,
  output logic [31:0] tick_count_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RETIRE = 4'b1000
  } trqs_state_e;

  trqs_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]  mode_q;
  logic [31:0] ticks_q;
  logic [7:0]  tid_q;
  logic [23:0] arr_q;
  logic [15:0] left_q;
  logic [7:0]  prio_q;
  logic        slot_found_q;
  logic        full_q;
  logic        out_valid_q;
  logic [7:0]  running_id_q;
  logic        runs_q;
  logic        empty_q;
  logic        full_out_q;
  logic [31:0] tick_out_q;

  trqs_cmd_t cmd;
  logic [MAX_THREADS-1:0] pick;
  logic [MAX_THREADS-1:0] hit_vec, free_vec, hit_first, free_first;
  logic      retire_go;
  trqs_stat_t stat [MAX_THREADS];
  trqs_tok_t  pre_chain  [MAX_THREADS+1];
  trqs_tok_t  post_chain [MAX_THREADS+1];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      hit_vec[i]  = stat[i].hit;
      free_vec[i] = !stat[i].valid;
    end
    hit_first  = hit_vec & (~hit_vec + MAX_THREADS'(1));
    free_first = free_vec & (~free_vec + MAX_THREADS'(1));
  end

  assign retire_go = (state_q == ST_RETIRE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd.op   = OP_HOLD;
    cmd.mode = mode_q;
    cmd.tid  = tid_q;
    cmd.arr  = arr_q;
    cmd.left = left_q;
    cmd.prio = prio_q;
    pick     = '0;
    state_d  = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (|hit_vec) begin
          cmd.op = OP_UPDATE;
          pick   = hit_first;
        end else if ((left_q != 16'd0) && (|free_vec)) begin
          cmd.op = OP_INSERT;
          pick   = free_first;
        end else begin
          cmd.op = OP_UPDATE; // clears the per-request flags only
        end
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == CNT_W'(MAX_THREADS - 1)) state_d = ST_RETIRE;
      end
      ST_RETIRE: begin
        if (retire_go) begin
          cmd.op  = OP_RETIRE;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      mode_q       <= MODE_FCFS;
      ticks_q      <= 32'd0;
      slot_found_q <= 1'b0;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) mode_q <= policy_mode_i;
      if (state_q == ST_LOOKUP) begin
        cnt_q        <= '0;
        slot_found_q <= (cmd.op == OP_INSERT) || (|hit_vec);
        full_q       <= !(|hit_vec) && (left_q != 16'd0) && !(|free_vec);
        if (left_q != 16'd0) ticks_q <= ticks_q + 32'd1;
      end else if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (retire_go) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      tid_q  <= thread_id_i;
      arr_q  <= arrival_time_i;
      left_q <= time_left_i;
      prio_q <= thread_priority_i;
    end
    if (retire_go) begin
      running_id_q <= post_chain[MAX_THREADS].found ? post_chain[MAX_THREADS].id : 8'd0;
      runs_q       <= slot_found_q && pre_chain[MAX_THREADS].found &&
                      pre_chain[MAX_THREADS].is_req;
      empty_q      <= !post_chain[MAX_THREADS].found;
      full_out_q   <= full_q;
      tick_out_q   <= ticks_q;
    end
  end

  assign pre_chain[0]  = '0;
  assign post_chain[0] = '0;

  for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
    trqs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .pick_i     (pick[g]),
      .tok_pre_i  (pre_chain[g]),
      .tok_post_i (post_chain[g]),
      .tok_pre_o  (pre_chain[g+1]),
      .tok_post_o (post_chain[g+1]),
      .stat_o     (stat[g])
    );
  end

  assign out_valid_o      = out_valid_q;
  assign running_id_o     = running_id_q;
  assign requester_runs_o = runs_q;
  assign queue_empty_o    = empty_q;
  assign table_full_o     = full_out_q;
  assign tick_count_o     = tick_out_q;

  // thread ids are unique in the table, so a lookup hits at most one slot
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> $onehot0(hit_vec))
    else $error("more than one slot holds the requested thread");

  a_result_from_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RETIRE))
    else $error("result raised outside the retire step");

  a_empty_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && empty_q) |-> (running_id_q == 8'd0))
    else $error("empty table reports a running thread");

  a_drop_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(runs_q && full_out_q))
    else $error("dropped request reported as running");

  a_scan_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RETIRE) && $past(state_q == ST_SCAN) |->
      $past(cnt_q == CNT_W'(MAX_THREADS - 1)))
    else $error("scan left before the candidate crossed every slot");

endmodule

// ===== test/trqs_checker.sv =====
// result checker for the thread ready-queue scheduler: follows the request,
// config and result channels, keeps its own copy of the thread table and
// compares every result; depends on trqs_pkg
`timescale 1ns / 1ps
module trqs_checker import trqs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  thread_id_i,
  input  logic [23:0] arrival_time_i,
  input  logic [15:0] time_left_i,
  input  logic [7:0]  thread_priority_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  policy_mode_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  running_id_i,
  input  logic        requester_runs_i,
  input  logic        queue_empty_i,
  input  logic        table_full_i,
  input  logic [31:0] tick_count_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          dropped_o,
  output int          ran_o
);

  typedef struct packed {
    logic [7:0]  running_id;
    logic        runs;
    logic        empty;
    logic        full;
    logic [31:0] ticks;
  } decision_t;

  // shadow thread table
  logic        slot_used  [MAX_THREADS];
  logic [7:0]  slot_id    [MAX_THREADS];
  logic [7:0]  slot_prio  [MAX_THREADS];
  logic [23:0] slot_first [MAX_THREADS];
  logic [23:0] slot_last  [MAX_THREADS];
  logic [15:0] slot_rem   [MAX_THREADS];
  logic [31:0] slot_seq   [MAX_THREADS];
  logic [31:0] ins_cnt;
  logic [31:0] ticks;
  logic [1:0]  mode;

  decision_t   decision_q [$];
  decision_t   head;
  int          fails;
  int          dropped;
  int          ran;

  // true if slot a should run ahead of slot b
  function automatic bit goes_ahead(int a, int b);
    logic [31:0] age_a;
    logic [31:0] age_b;
    bit          res;
    age_a = ins_cnt - slot_seq[a];
    age_b = ins_cnt - slot_seq[b];
    case (mode)
      MODE_PRIO: begin
        if (slot_prio[a] != slot_prio[b]) res = slot_prio[a] < slot_prio[b];
        else if (slot_first[a] != slot_first[b]) res = slot_first[a] < slot_first[b];
        else res = age_a < age_b;
      end
      MODE_SRTF: begin
        if (slot_rem[a] != slot_rem[b]) res = slot_rem[a] < slot_rem[b];
        else if (slot_last[a] != slot_last[b]) res = slot_last[a] < slot_last[b];
        else res = age_a > age_b;
      end
      default: res = age_a > age_b;
    endcase
    return res;
  endfunction

  // index of the thread to run, MAX_THREADS when the table is empty
  function automatic int pick_slot();
    int best;
    best = MAX_THREADS;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (slot_used[i] && (best == MAX_THREADS || goes_ahead(i, best))) best = i;
    end
    return best;
  endfunction

  function automatic decision_t predict_decision(logic [7:0] tid, logic [23:0] arr,
                                                 logic [15:0] left, logic [7:0] prio);
    decision_t d;
    int        hit;
    int        vacant;
    int        best;
    d = '0;
    hit = MAX_THREADS;
    vacant = MAX_THREADS;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (slot_used[i]) begin
        if (slot_id[i] == tid && hit == MAX_THREADS) hit = i;
      end else if (vacant == MAX_THREADS) begin
        vacant = i;
      end
    end
    if (hit < MAX_THREADS) begin
      // held thread: priority and first arrival are kept
      slot_last[hit] = arr;
      slot_rem[hit]  = left;
    end else if (left != '0) begin
      if (vacant < MAX_THREADS) begin
        hit = vacant;
        slot_used[hit]  = 1'b1;
        slot_id[hit]    = tid;
        slot_prio[hit]  = prio;
        slot_first[hit] = arr;
        slot_last[hit]  = arr;
        slot_rem[hit]   = left;
        slot_seq[hit]   = ins_cnt;
        ins_cnt++;
      end else begin
        d.full = 1'b1;
      end
    end
    best = pick_slot();
    d.runs = (hit < MAX_THREADS) && (best == hit);
    // a finishing thread is judged before it leaves the table
    if (left == '0 && hit < MAX_THREADS) begin
      slot_used[hit] = 1'b0;
      best = pick_slot();
    end
    if (left != '0) ticks++;
    d.running_id = (best < MAX_THREADS) ? slot_id[best] : 8'd0;
    d.empty      = (best == MAX_THREADS);
    d.ticks      = ticks;
    return d;
  endfunction

  function automatic int field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        slot_used[i]  = 1'b0;
        slot_id[i]    = '0;
        slot_prio[i]  = '0;
        slot_first[i] = '0;
        slot_last[i]  = '0;
        slot_rem[i]   = '0;
        slot_seq[i]   = '0;
      end
      ins_cnt = '0;
      ticks   = '0;
      mode    = MODE_FCFS;
      decision_q.delete();
      fails   = 0;
      dropped = 0;
      ran     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) mode = policy_mode_i;
      if (in_valid_i && !in_stall_i) begin
        head = predict_decision(thread_id_i, arrival_time_i, time_left_i,
                                thread_priority_i);
        dropped += head.full;
        ran     += head.runs;
        decision_q.push_back(head);
      end
      if (out_valid_i && !out_stall_i) begin
        if (decision_q.size() == 0) begin
          $error("result with no request outstanding: running_id %0d", running_id_i);
          fails++;
        end else begin
          head = decision_q.pop_front();
          fails += field_check("running_id", 32'(head.running_id), 32'(running_id_i));
          fails += field_check("requester_runs", 32'(head.runs), 32'(requester_runs_i));
          fails += field_check("queue_empty", 32'(head.empty), 32'(queue_empty_i));
          fails += field_check("table_full", 32'(head.full), 32'(table_full_i));
          fails += field_check("tick_count", head.ticks, tick_count_i);
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= decision_q.size();
    dropped_o    <= dropped;
    ran_o        <= ran;
  end

endmodule

// ===== test/tb_thread_ready_queue_scheduler.sv =====
// testbench top for thread_ready_queue_scheduler: drives requests, policy writes
// and result stalls, and gives the verdict; depends on trqs_pkg and trqs_checker
`timescale 1ns / 1ps
module tb_thread_ready_queue_scheduler;
  import trqs_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3; // unused code, behaves as fcfs
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  thread_id = '0;
  logic [23:0] arrival_time = '0;
  logic [15:0] time_left = '0;
  logic [7:0]  thread_priority = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  policy_mode = MODE_FCFS;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  running_id;
  logic        requester_runs;
  logic        queue_empty;
  logic        table_full;
  logic [31:0] tick_count;

  int fail_count;
  int pending;
  int dropped;
  int ran;
  int sent = 0;
  int gap_top = 7;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  thread_ready_queue_scheduler i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .thread_id_i       (thread_id),
    .arrival_time_i    (arrival_time),
    .time_left_i       (time_left),
    .thread_priority_i (thread_priority),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .policy_mode_i     (policy_mode),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .running_id_o      (running_id),
    .requester_runs_o  (requester_runs),
    .queue_empty_o     (queue_empty),
    .table_full_o      (table_full),
    .tick_count_o      (tick_count)
  );

  trqs_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .thread_id_i       (thread_id),
    .arrival_time_i    (arrival_time),
    .time_left_i       (time_left),
    .thread_priority_i (thread_priority),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .policy_mode_i     (policy_mode),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .running_id_i      (running_id),
    .requester_runs_i  (requester_runs),
    .queue_empty_i     (queue_empty),
    .table_full_i      (table_full),
    .tick_count_i      (tick_count),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .dropped_o         (dropped),
    .ran_o             (ran)
  );

  // one request, then the sender's own pause before the next
  task automatic push_request(logic [7:0] tid, logic [23:0] arr, logic [15:0] left,
                              logic [7:0] prio);
    int gap;
    in_valid        <= 1'b1;
    thread_id       <= tid;
    arrival_time    <= arr;
    time_left       <= left;
    thread_priority <= prio;
    do @(posedge clk); while (in_stall);
    sent++;
    gap = $urandom_range(0, gap_top);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly a small id pool and small values so that ties and a full table turn up
  task automatic random_request(int pool, logic [23:0] now);
    logic [7:0]  tid;
    logic [23:0] arr;
    logic [15:0] left;
    logic [7:0]  prio;
    int          roll;
    roll = $urandom_range(0, 99);
    tid  = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, pool - 1));
    if (roll < 22) left = '0;
    else if (roll < 90) left = 16'($urandom_range(1, 6));
    else left = 16'($urandom_range(1, 16'hFFFF));
    prio = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                       : 8'($urandom_range(0, 255));
    arr  = ($urandom_range(0, 4) != 0) ? now : 24'($urandom_range(0, 24'hFFFFFF));
    push_request(tid, arr, left, prio);
  endtask

  // drop valid, wait for every result, then hold the block idle before the next phase
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    cfg_valid   <= 1'b1;
    policy_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls per result, one long hold-off to back the block up
  initial begin
    int hold;
    int taken;
    int stall_top;
    taken = 0;
    stall_top = 7;
    wait (rst_n);
    forever begin
      hold = (taken == 300) ? LONG_HOLD : $urandom_range(0, stall_top);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
      if (taken % 64 == 0) stall_top = ($urandom_range(0, 3) == 0) ? 0 : 7;
    end
  end

  initial begin
    logic [1:0]  plan [8];
    logic [23:0] now;
    int          pool;
    plan = '{MODE_PRIO, MODE_SRTF, MODE_SPARE, MODE_FCFS,
             MODE_SRTF, MODE_PRIO, MODE_FCFS, MODE_SRTF};
    now = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // finished thread that was never held, on an empty table
    push_request(8'd5, 24'd0, 16'd0, 8'd0);
    push_request(8'd0, 24'd0, 16'd1, 8'd0);
    push_request(8'd255, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    // held thread gets new times, its priority stays
    push_request(8'd0, 24'h000100, 16'd2, 8'h80);
    for (int i = 1; i <= 14; i++) begin
      push_request(8'(i), 24'(i * 256), 16'(i), 8'(i % 4));
    end
    // table now full: new thread dropped, then an unknown one finishes
    push_request(8'd200, 24'h123456, 16'd7, 8'd1);
    push_request(8'd200, 24'h123457, 16'd0, 8'd1);
    // running thread finishes, freed slot is reused
    push_request(8'd0, 24'h000200, 16'd0, 8'd0);
    push_request(8'd77, 24'hABCDEF, 16'h8000, 8'd3);
    settle();

    foreach (plan[p]) begin
      write_mode(plan[p]);
      gap_top = (p % 3 == 1) ? 0 : 7;
      case (p % 4)
        0: pool = 6;
        1: pool = 14;
        2: pool = 24;
        default: pool = 40;
      endcase
      repeat (112) begin
        now += 24'($urandom_range(0, 2));
        random_request(pool, now);
      end
      settle();
    end

    $display("%0d requests under all four mode codes, table carried across mode changes",
             sent);
    $display("%0d new threads dropped on a full table, %0d requests found their thread running",
             dropped, ran);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
